@@ hw/rtl/rlpm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlpm_pkg
// Shared types and constants of the region luma peak meter.
// ----------------------------------------------------------------------------
package rlpm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_RED_WEIGHT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_WEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_WEIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE      = 3'd4;

	localparam logic [7:0]  RED_WEIGHT_RST   = 8'd77;
	localparam logic [7:0]  GREEN_WEIGHT_RST = 8'd150;
	localparam logic [7:0]  BLUE_WEIGHT_RST  = 8'd29;
	localparam logic [23:0] REGION_SCALE_RST = 24'd16384;
	localparam logic [15:0] OVERRIDE_RST     = 16'd0;

	localparam logic [1:0] TRI_BOTTOM = 2'd0;
	localparam logic [1:0] TRI_LEFT   = 2'd1;
	localparam logic [1:0] TRI_RIGHT  = 2'd2;
	localparam logic [1:0] TRI_TOP    = 2'd3;

	localparam int LUMA_W  = 18;
	localparam int SUM_W   = 32;
	localparam int PROD_W  = 56;
	localparam int LEVEL_W = 16;
	localparam int SCALE_SHIFT = 24;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       hidden;
	} pix_t;

	typedef struct packed {
		logic [15:0] light_level;
		logic [15:0] frame_level;
	} res_t;

	typedef struct packed {
		logic [7:0]  red_weight;
		logic [7:0]  green_weight;
		logic [7:0]  blue_weight;
		logic [23:0] region_scale;
		logic [15:0] override_level;
	} cfg_t;

	typedef struct packed {
		logic accept;     // pixel taken this cycle
		logic mul;        // scale the selected triangle sum
		logic cmp;        // fold scaled level into the frame maximum
		logic hist_wr;    // store frame level into the ring
		logic peak_step;  // fold one ring slot into the peak
		logic finish;     // load result, advance slot and countdown unless hidden, clear sums
	} cmd_t;

	typedef struct packed {
		logic last_pix;
		logic tri_last;
		logic peak_last;
	} st_t;

endpackage
`default_nettype wire

@@ hw/rtl/rlpm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlpm_ctrl
// Frame sequencer: pixel intake, frame-end scaling and peak search, result
// hand-off.
// ----------------------------------------------------------------------------
module rlpm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pix_valid,
	output logic               pix_ready,
	output logic               res_valid,
	input  wire logic          res_ready,
	input  wire rlpm_pkg::st_t st,
	output rlpm_pkg::cmd_t     cmd
);
	import rlpm_pkg::*;

	typedef enum logic [2:0] {
		S_ACCUM,
		S_FLUSH,
		S_MUL,
		S_CMP,
		S_HWR,
		S_PEAK,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   fin_go;

	assign fin_go    = (state_q == S_FINISH) && (!res_valid_q || res_ready);
	assign pix_ready = (state_q == S_ACCUM);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.accept    = (state_q == S_ACCUM) && pix_valid;
		cmd.mul       = (state_q == S_MUL);
		cmd.cmp       = (state_q == S_CMP);
		cmd.hist_wr   = (state_q == S_HWR);
		cmd.peak_step = (state_q == S_PEAK);
		cmd.finish    = fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACCUM;
			res_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_ACCUM: begin
					if (pix_valid && st.last_pix) begin
						state_q <= S_FLUSH;
					end
				end
				// let the last pixel land in its sum
				S_FLUSH: state_q <= S_MUL;
				S_MUL:   state_q <= S_CMP;
				S_CMP: begin
					state_q <= st.tri_last ? S_HWR : S_MUL;
				end
				S_HWR: state_q <= S_PEAK;
				S_PEAK: begin
					if (st.peak_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						state_q <= S_ACCUM;
					end
				end
				default: state_q <= S_ACCUM;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/rlpm_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rlpm_dp
// Datapath: luma weighting, triangle sums, level scaling, history ring and
// result register.
// ----------------------------------------------------------------------------
module rlpm_dp #(
	parameter int SIDE        = 64,
	parameter int HISTORY     = 2,
	parameter int DARK_FRAMES = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rlpm_pkg::cmd_t cmd,
	input  wire rlpm_pkg::pix_t pix,
	input  wire rlpm_pkg::cfg_t cfg,
	output rlpm_pkg::st_t       st,
	output rlpm_pkg::res_t      res
);
	import rlpm_pkg::*;

	localparam int IDX_W  = $clog2(SIDE);
	localparam int SLOT_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SIDE - 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY - 1);

	logic [IDX_W-1:0]   row_q, col_q;
	logic [LUMA_W-1:0]  luma_s1;
	logic [1:0]         tri_s1;
	logic               valid_s1;
	logic               hidden_q;
	logic [SUM_W-1:0]   sums_q [4];
	logic [1:0]         k_q;
	logic [PROD_W-1:0]  prod_q;
	logic [LEVEL_W-1:0] max_q;
	logic [LEVEL_W-1:0] hist_q [HISTORY];
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  j_q;
	logic [LEVEL_W-1:0] peak_q;
	logic [7:0]         cd_q;
	res_t               res_q;

	logic [IDX_W:0]     rc_sum;
	logic [IDX_W-1:0]   col_lim;
	logic [1:0]         tri_sel;
	logic [15:0]        p_r, p_g, p_b;
	logic [LUMA_W-1:0]  luma;
	logic [SUM_W:0]     acc;
	logic [SUM_W-1:0]   acc_sat;
	logic [PROD_W-SCALE_SHIFT-1:0] lv_wide;
	logic [LEVEL_W-1:0] lv;

	always_comb begin
		rc_sum  = {1'b0, row_q} + {1'b0, col_q};
		col_lim = LAST_IDX - row_q;
		if (col_q <= row_q && rc_sum >= {1'b0, LAST_IDX}) begin
			tri_sel = TRI_BOTTOM;
		end else if (col_q < row_q) begin
			tri_sel = TRI_LEFT;
		end else if (col_q > col_lim) begin
			tri_sel = TRI_RIGHT;
		end else begin
			tri_sel = TRI_TOP;
		end
	end

	assign p_r  = 16'(pix.red)   * 16'(cfg.red_weight);
	assign p_g  = 16'(pix.green) * 16'(cfg.green_weight);
	assign p_b  = 16'(pix.blue)  * 16'(cfg.blue_weight);
	assign luma = LUMA_W'(p_r) + LUMA_W'(p_g) + LUMA_W'(p_b);

	assign acc     = {1'b0, sums_q[tri_s1]} + (SUM_W+1)'(luma_s1);
	assign acc_sat = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];

	assign lv_wide = prod_q[PROD_W-1:SCALE_SHIFT];
	assign lv      = (|lv_wide[PROD_W-SCALE_SHIFT-1:LEVEL_W]) ? {LEVEL_W{1'b1}}
	                                                          : lv_wide[LEVEL_W-1:0];

	assign st.last_pix  = (row_q == LAST_IDX) && (col_q == LAST_IDX);
	assign st.tri_last  = (k_q == TRI_TOP);
	assign st.peak_last = (j_q == LAST_SLOT);
	assign res          = res_q;

	// pixel stage and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.accept;
			if (cmd.accept) begin
				if (col_q == LAST_IDX) begin
					col_q <= '0;
					row_q <= (row_q == LAST_IDX) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			luma_s1 <= luma;
			tri_s1  <= tri_sel;
			if (st.last_pix) begin
				hidden_q <= pix.hidden;
			end
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(sums_q[k_q]) * PROD_W'(cfg.region_scale);
		end
		if (cmd.cmp) begin
			if (k_q == TRI_BOTTOM || lv > max_q) begin
				max_q <= lv;
			end
		end
		if (cmd.hist_wr) begin
			peak_q <= '0;
		end else if (cmd.peak_step) begin
			if (hist_q[j_q] > peak_q) begin
				peak_q <= hist_q[j_q];
			end
		end
	end

	// triangle sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				sums_q[i] <= '0;
			end
		end else if (cmd.finish) begin
			for (int i = 0; i < 4; i++) begin
				sums_q[i] <= '0;
			end
		end else if (valid_s1) begin
			sums_q[tri_s1] <= acc_sat;
		end
	end

	// frame-end sequencing counters, history ring, countdown, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			j_q    <= '0;
			slot_q <= '0;
			cd_q   <= 8'(DARK_FRAMES);
			for (int i = 0; i < HISTORY; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (cmd.cmp) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.peak_step) begin
				j_q <= st.peak_last ? '0 : j_q + 1'b1;
			end
			if (cmd.hist_wr) begin
				hist_q[slot_q] <= max_q;
			end
			if (cmd.finish && !hidden_q) begin
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
				if (cd_q != 8'd0) begin
					cd_q <= cd_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.frame_level <= max_q;
			if (hidden_q) begin
				res_q.light_level <= '0;
			end else if (cd_q != 8'd0) begin
				res_q.light_level <= cfg.override_level;
			end else begin
				res_q.light_level <= peak_q;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/region_luma_peak_meter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// region_luma_peak_meter
// Per-frame luma level meter over four diagonal triangles with peak hold.
// ----------------------------------------------------------------------------
// Usage:
//   pix carries one RGB pixel per item, SIDE x SIDE items per frame in raster
//   order, row outer. Each pixel's weighted luma is added to its triangle.
//   res carries one item per frame: the scaled peak of the four triangles
//   (frame_level) and the reported light_level (history peak, zero when the
//   last pixel is hidden, override_level while the startup countdown runs).
//   cfg writes the weights, scale and override level; it is always ready.
// Throughput and frame end:
//   One pixel per cycle within a frame. After the last pixel the frame-end
//   sequence holds pix_ready low while it settles the last sum, scales each
//   triangle on the shared 32x24 multiplier and folds it into the frame
//   maximum, writes the ring, searches the ring slots for the peak and loads
//   the result. res_valid rises together with the result load.
// Reset:
//   Sums, counters and ring clear to zero, the countdown loads DARK_FRAMES,
//   registers take their defaults.
// Stall:
//   The result register holds one item; pixels of the next frame are taken
//   while it waits, and the next frame end waits until it is taken.
// ----------------------------------------------------------------------------
module region_luma_peak_meter #(
	parameter int SIDE        = 64,
	parameter int HISTORY     = 2,
	parameter int DARK_FRAMES = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               pix_valid,
	output logic                                    pix_ready,
	input  wire rlpm_pkg::pix_t                     pix,
	output logic                                    res_valid,
	input  wire logic                               res_ready,
	output rlpm_pkg::res_t                          res,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rlpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rlpm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rlpm_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	st_t  st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_weight     <= RED_WEIGHT_RST;
			cfg_q.green_weight   <= GREEN_WEIGHT_RST;
			cfg_q.blue_weight    <= BLUE_WEIGHT_RST;
			cfg_q.region_scale   <= REGION_SCALE_RST;
			cfg_q.override_level <= OVERRIDE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RED_WEIGHT:   cfg_q.red_weight     <= cfg_data[7:0];
				CFG_GREEN_WEIGHT: cfg_q.green_weight   <= cfg_data[7:0];
				CFG_BLUE_WEIGHT:  cfg_q.blue_weight    <= cfg_data[7:0];
				CFG_REGION_SCALE: cfg_q.region_scale   <= cfg_data;
				CFG_OVERRIDE:     cfg_q.override_level <= cfg_data[15:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	rlpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.st        (st),
		.cmd       (cmd)
	);

	rlpm_dp #(
		.SIDE        (SIDE),
		.HISTORY     (HISTORY),
		.DARK_FRAMES (DARK_FRAMES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pix    (pix),
		.cfg    (cfg_q),
		.st     (st),
		.res    (res)
	);

`ifndef SYNTH
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.mul, cmd.cmp, cmd.hist_wr, cmd.peak_step, cmd.finish}))
		else $error("more than one datapath command in a cycle");

	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && st.last_pix) |=> !pix_ready)
		else $error("pixel intake continued past the frame end");

	a_res_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd.finish))
		else $error("result appeared without a frame finish");
`endif

endmodule
`default_nettype wire
